FILE: design/ssl_pkg.sv
// shared types, constants and the per-byte lexer step function
`default_nettype none
package ssl_pkg;

    localparam int LINE_WIDTH  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // lexer state codes
    localparam logic [3:0] ST_START     = 4'd0;
    localparam logic [3:0] ST_IDENT     = 4'd1;
    localparam logic [3:0] ST_STR1      = 4'd2;
    localparam logic [3:0] ST_STR2      = 4'd3;
    localparam logic [3:0] ST_NUM       = 4'd4;
    localparam logic [3:0] ST_SLASH     = 4'd5;
    localparam logic [3:0] ST_BLOCK     = 4'd6;
    localparam logic [3:0] ST_LINECMT   = 4'd7;
    localparam logic [3:0] ST_BLOCKSTAR = 4'd8;

    // token classes
    localparam logic [2:0] CL_IDENT = 3'd0;
    localparam logic [2:0] CL_PUNCT = 3'd1;
    localparam logic [2:0] CL_NUM   = 3'd2;
    localparam logic [2:0] CL_STR   = 3'd3;
    localparam logic [2:0] CL_UNK   = 3'd4;
    localparam logic [2:0] CL_EOF   = 3'd5;

    // character codes
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef struct packed {
        logic       has_char;
        logic [7:0] token_char;
        logic       token_done;
        logic [2:0] token_class;
    } tok_t;

    typedef struct packed {
        logic        has_char;
        logic [7:0]  token_char;
        logic        token_done;
        logic [2:0]  token_class;
        logic [15:0] line_number;
        logic        last_result;
    } res_t;

    // all results caused by one request
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } bundle_t;

    typedef struct packed {
        logic       emit;
        tok_t       tok;
        logic [3:0] nstate;
        logic       nesc;
        logic       bump;
        logic       again;
    } pass_t;

    typedef struct packed {
        logic valid;
        logic full;
    } qstat_t;

    function automatic tok_t mk_tok(input logic hc, input logic [7:0] ch,
                                    input logic done, input logic [2:0] cls);
        tok_t t;
        t.has_char    = hc;
        t.token_char  = hc ? ch : 8'd0;
        t.token_done  = done;
        t.token_class = cls;
        return t;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c == 8'h7B || c == 8'h7D || c == 8'h26 || c == 8'h7C || c == CH_STAR ||
               c == 8'h3B || c == 8'h3D || c == 8'h28 || c == 8'h29 || c == 8'h2C ||
               c == 8'h5B || c == 8'h5D;
    endfunction

    // one pass of the lexer over a byte from a given state
    function automatic pass_t lex_pass(input logic [3:0] st, input logic esc,
                                       input logic [7:0] b);
        pass_t      p;
        logic [7:0] q;
        p.emit   = 1'b0;
        p.tok    = mk_tok(1'b0, 8'd0, 1'b0, CL_IDENT);
        p.nstate = st;
        p.nesc   = esc;
        p.bump   = 1'b0;
        p.again  = 1'b0;
        q        = (st == ST_STR1) ? CH_SQUOTE : CH_DQUOTE;
        unique case (st)
            ST_SLASH:
            begin
                if (b == CH_STAR)
                    p.nstate = ST_BLOCK;
                else if (b == CH_SLASH)
                    p.nstate = ST_LINECMT;
                else
                begin
                    p.emit   = 1'b1;
                    p.tok    = mk_tok(1'b1, CH_SLASH, 1'b1, CL_UNK);
                    p.nstate = ST_START;
                    p.again  = 1'b1;
                end
            end
            ST_BLOCK:
            begin
                if (b == CH_STAR)
                    p.nstate = ST_BLOCKSTAR;
                else if (b == CH_LF)
                    p.bump = 1'b1;
            end
            ST_BLOCKSTAR:
            begin
                if (b == CH_SLASH)
                    p.nstate = ST_START;
                else if (b != CH_STAR)
                begin
                    p.nstate = ST_BLOCK;
                    p.bump   = (b == CH_LF);
                end
            end
            ST_LINECMT:
            begin
                if (b == CH_LF)
                begin
                    p.nstate = ST_START;
                    p.bump   = 1'b1;
                end
            end
            ST_IDENT:
            begin
                p.emit = 1'b1;
                if (is_alpha(b) || is_digit(b))
                    p.tok = mk_tok(1'b1, b, 1'b0, CL_IDENT);
                else
                begin
                    p.tok    = mk_tok(1'b0, 8'd0, 1'b1, CL_IDENT);
                    p.nstate = ST_START;
                    p.again  = 1'b1;
                end
            end
            ST_NUM:
            begin
                p.emit = 1'b1;
                if (is_digit(b) || b == CH_PLUS || b == CH_MINUS)
                    p.tok = mk_tok(1'b1, b, 1'b0, CL_NUM);
                else
                begin
                    p.tok    = mk_tok(1'b0, 8'd0, 1'b1, CL_NUM);
                    p.nstate = ST_START;
                    p.again  = 1'b1;
                end
            end
            ST_STR1, ST_STR2:
            begin
                priority if (esc)
                begin
                    p.nesc = 1'b0;
                    p.emit = 1'b1;
                    p.tok  = mk_tok(1'b1, b, 1'b0, CL_STR);
                end
                else if (b == q)
                begin
                    p.emit   = 1'b1;
                    p.tok    = mk_tok(1'b0, 8'd0, 1'b1, CL_STR);
                    p.nstate = ST_START;
                end
                else if (b == CH_BSLASH)
                    p.nesc = 1'b1;
                else
                begin
                    p.emit = 1'b1;
                    p.tok  = mk_tok(1'b1, b, 1'b0, CL_STR);
                end
            end
            default:
            begin
                p.nstate = ST_START;
                priority if (b == CH_SPACE || b == CH_CR || b == CH_TAB)
                    p.emit = 1'b0;
                else if (b == CH_LF)
                    p.bump = 1'b1;
                else if (is_punct(b))
                begin
                    p.emit = 1'b1;
                    p.tok  = mk_tok(1'b1, b, 1'b1, CL_PUNCT);
                end
                else if (b == CH_SLASH)
                    p.nstate = ST_SLASH;
                else if (is_alpha(b))
                begin
                    p.nstate = ST_IDENT;
                    p.emit   = 1'b1;
                    p.tok    = mk_tok(1'b1, b, 1'b0, CL_IDENT);
                end
                else if (b == CH_PLUS || b == CH_MINUS || is_digit(b))
                begin
                    p.nstate = ST_NUM;
                    p.emit   = 1'b1;
                    p.tok    = mk_tok(1'b1, b, 1'b0, CL_NUM);
                end
                else if (b == CH_SQUOTE)
                begin
                    p.nstate = ST_STR1;
                    p.nesc   = 1'b0;
                end
                else if (b == CH_DQUOTE)
                begin
                    p.nstate = ST_STR2;
                    p.nesc   = 1'b0;
                end
                else
                begin
                    p.emit = 1'b1;
                    p.tok  = mk_tok(1'b1, b, 1'b1, CL_UNK);
                end
            end
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

FILE: design/ssl_if.sv
// byte request and token result channel interfaces
`default_nettype none
interface ssl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_req;
    logic       end_of_input;

    modport source (output valid, output byte_req, output end_of_input, input ready);
    modport sink (input valid, input byte_req, input end_of_input, output ready);
endinterface

interface ssl_out_if;
    logic        valid;
    logic        ready;
    logic        has_char;
    logic [7:0]  token_char;
    logic        token_done;
    logic [2:0]  token_class;
    logic [15:0] line_number;
    logic        last_result;

    modport source (output valid, output has_char, output token_char, output token_done,
                    output token_class, output line_number, output last_result,
                    input ready);
    modport sink (input valid, input has_char, input token_char, input token_done,
                  input token_class, input line_number, input last_result,
                  output ready);
endinterface
`default_nettype wire

FILE: design/script_source_lexer_core.sv
// script source lexer top level: front end, bundle queue and back end
// path: the results of a byte are written to the bundle queue, then loaded into the output register
// throughput: one byte per cycle while the two-entry bundle queue has room;
//   results leave one per cycle while the receiver is ready, so a token-ending byte may give two in turn
// reset: lexer at start state, escape clear, line count one, queue and output empty
`default_nettype none
module script_source_lexer_core
    import ssl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ssl_in_if.sink    byte_chan,
    ssl_out_if.source token_chan
);

    qstat_t  q_stat;
    logic    push;
    bundle_t push_data;
    logic    pop;
    bundle_t head;

    // byte classification and lexer state
    ssl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_chan (byte_chan),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // bundle queue
    ssl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .q_stat    (q_stat),
        .head      (head)
    );

    // result output
    ssl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .head       (head),
        .pop        (pop),
        .token_chan (token_chan)
    );

    // checks
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("bundle pushed into full queue");

    a_eof_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        byte_chan.valid && byte_chan.ready && byte_chan.end_of_input |-> push)
        else $error("end of input request produced no result");

    a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
        token_chan.valid && token_chan.token_class == CL_EOF
            |-> token_chan.token_done && token_chan.last_result && !token_chan.has_char)
        else $error("malformed end token");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        token_chan.valid && !token_chan.has_char |-> token_chan.token_char == 8'd0)
        else $error("token char set without has_char");

endmodule
`default_nettype wire

FILE: design/ssl_front.sv
// front end: accepts bytes, runs the lexer state machine, builds result bundles
`default_nettype none
module ssl_front
    import ssl_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    ssl_in_if.sink       byte_chan,
    input  wire qstat_t  q_stat,
    output logic         push,
    output bundle_t      push_data
);

    logic [3:0]            state_reg, state_next;
    logic                  esc_reg, esc_next;
    logic [LINE_WIDTH-1:0] line_reg, line_next;

    pass_t       pass1, pass2;
    logic        accept;
    logic        bump;
    logic [31:0] line_wide;
    logic [15:0] line_out;
    logic [1:0]  cnt;
    tok_t        t0;

    assign byte_chan.ready = !q_stat.full;
    assign accept          = byte_chan.valid && byte_chan.ready;

    // first pass from the current state, second pass from start on a reprocess
    always_comb
    begin
        pass1 = lex_pass(state_reg, esc_reg, byte_chan.byte_req);
        pass2 = lex_pass(ST_START, pass1.nesc, byte_chan.byte_req);
    end

    assign line_wide = 32'(line_reg);
    assign line_out  = line_wide[15:0];

    // next state and result bundle
    always_comb
    begin
        state_next = state_reg;
        esc_next   = esc_reg;
        line_next  = line_reg;
        bump       = 1'b0;
        cnt        = 2'd0;
        t0         = pass1.tok;
        if (byte_chan.end_of_input)
        begin
            state_next = ST_START;
            esc_next   = 1'b0;
            cnt        = 2'd1;
            t0         = mk_tok(1'b0, 8'd0, 1'b1, CL_EOF);
        end
        else if (pass1.again)
        begin
            state_next = pass2.nstate;
            esc_next   = pass2.nesc;
            bump       = pass2.bump;
            cnt        = 2'(pass1.emit) + 2'(pass2.emit);
            t0         = pass1.emit ? pass1.tok : pass2.tok;
        end
        else
        begin
            state_next = pass1.nstate;
            esc_next   = pass1.nesc;
            bump       = pass1.bump;
            cnt        = 2'(pass1.emit);
        end
        if (bump && line_reg != {LINE_WIDTH{1'b1}})
            line_next = line_reg + 1'b1;

        push_data.cnt            = cnt;
        push_data.r0.has_char    = t0.has_char;
        push_data.r0.token_char  = t0.token_char;
        push_data.r0.token_done  = t0.token_done;
        push_data.r0.token_class = t0.token_class;
        push_data.r0.line_number = line_out;
        push_data.r0.last_result = (cnt == 2'd1);
        push_data.r1.has_char    = pass2.tok.has_char;
        push_data.r1.token_char  = pass2.tok.token_char;
        push_data.r1.token_done  = pass2.tok.token_done;
        push_data.r1.token_class = pass2.tok.token_class;
        push_data.r1.line_number = line_out;
        push_data.r1.last_result = 1'b1;
    end

    assign push = accept && (cnt != 2'd0);

    // lexer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            esc_reg   <= 1'b0;
            line_reg  <= LINE_WIDTH'(1);
        end
        else if (accept)
        begin
            state_reg <= state_next;
            esc_reg   <= esc_next;
            line_reg  <= line_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/ssl_queue.sv
// small bundle queue between front and back ends
`default_nettype none
module ssl_queue
    import ssl_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire bundle_t push_data,
    input  wire logic    pop,
    output qstat_t       q_stat,
    output bundle_t      head
);

    bundle_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign q_stat.valid = (count_reg != '0);
    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && q_stat.valid;
    assign head         = mem[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

FILE: design/ssl_back.sv
// back end: splits bundles into single results behind an output register
`default_nettype none
module ssl_back
    import ssl_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire qstat_t  q_stat,
    input  wire bundle_t head,
    output logic         pop,
    ssl_out_if.source    token_chan
);

    logic out_valid_reg, out_valid_next;
    res_t out_reg;
    logic idx_reg, idx_next;
    logic load;
    res_t sel;

    assign load = q_stat.valid && (!out_valid_reg || token_chan.ready);
    assign sel  = idx_reg ? head.r1 : head.r0;
    assign pop  = load && (idx_reg || head.cnt == 2'd1);

    // output valid and result index
    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = !pop;
        end
        else if (token_chan.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= sel;
    end

    assign token_chan.valid       = out_valid_reg;
    assign token_chan.has_char    = out_reg.has_char;
    assign token_chan.token_char  = out_reg.token_char;
    assign token_chan.token_done  = out_reg.token_done;
    assign token_chan.token_class = out_reg.token_class;
    assign token_chan.line_number = out_reg.line_number;
    assign token_chan.last_result = out_reg.last_result;

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// self-checking testbench for the script source lexer core
`timescale 1ns / 100ps
module tb_top;
    import ssl_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 100;

    typedef struct packed {
        logic [7:0] code;
        logic       eoi;
        logic       drain;  // held back until every token is out
        logic       burst;  // no idle gap after this request
    } src_item_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // testbench-owned drive values, known from time zero
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'd0;
    logic       in_eoi    = 1'b0;
    logic       out_ready = 1'b0;

    ssl_in_if  byte_if ();
    ssl_out_if token_if ();

    assign byte_if.valid        = in_valid;
    assign byte_if.byte_req     = in_byte;
    assign byte_if.end_of_input = in_eoi;
    assign token_if.ready       = out_ready;

    script_source_lexer_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_chan  (byte_if),
        .token_chan (token_if)
    );

    always #2 clk = ~clk;

    // lexer shadow state
    logic [3:0]  lx_state = ST_START;
    logic        lx_esc   = 1'b0;
    logic [15:0] lx_line  = 16'd1;
    res_t        step_res [2];
    int          step_n;

    src_item_t source_bytes [$];
    res_t      pending_tokens [$];
    res_t      tok_want;
    src_item_t nxt;

    int   errors    = 0;
    int   sent_cnt  = 0;
    int   queued    = 0;
    int   cycles    = 0;
    int   tx_gap    = 0;
    int   rx_stall  = 0;
    int   hold_left = 0;
    bit   hold_used = 1'b0;
    bit   tx_calm   = 1'b0;
    bit   rx_calm   = 1'b0;
    bit   cur_burst = 1'b0;

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_UNDER;
    endfunction

    function automatic bit is_decimal(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_single_punct(input logic [7:0] c);
        return c == "{" || c == "}" || c == "&" || c == "|" || c == CH_STAR ||
               c == ";" || c == "=" || c == "(" || c == ")" || c == "," ||
               c == "[" || c == "]";
    endfunction

    task automatic bump_line();
        if (lx_line != 16'hFFFF)
            lx_line++;
    endtask

    task automatic add_token(input logic hc, input logic [7:0] ch, input logic done,
                             input logic [2:0] cls);
        step_res[step_n].has_char    = hc;
        step_res[step_n].token_char  = hc ? ch : 8'd0;
        step_res[step_n].token_done  = done;
        step_res[step_n].token_class = cls;
        step_res[step_n].line_number = lx_line;
        step_res[step_n].last_result = 1'b0;
        step_n++;
    endtask

    // one lexer pass over a byte; again is set when the byte must be rescanned
    task automatic lex_pass(input logic [7:0] b, output bit again);
        logic [7:0] quote;
        again = 1'b0;
        quote = (lx_state == ST_STR1) ? CH_SQUOTE : CH_DQUOTE;
        case (lx_state)
            ST_SLASH:
            begin
                if (b == CH_STAR)
                    lx_state = ST_BLOCK;
                else if (b == CH_SLASH)
                    lx_state = ST_LINECMT;
                else
                begin
                    add_token(1'b1, CH_SLASH, 1'b1, CL_UNK);
                    lx_state = ST_START;
                    again    = 1'b1;
                end
            end
            ST_BLOCK:
            begin
                if (b == CH_STAR)
                    lx_state = ST_BLOCKSTAR;
                else if (b == CH_LF)
                    bump_line();
            end
            ST_BLOCKSTAR:
            begin
                if (b == CH_SLASH)
                    lx_state = ST_START;
                else if (b != CH_STAR)
                begin
                    lx_state = ST_BLOCK;
                    if (b == CH_LF)
                        bump_line();
                end
            end
            ST_LINECMT:
            begin
                if (b == CH_LF)
                begin
                    lx_state = ST_START;
                    bump_line();
                end
            end
            ST_IDENT:
            begin
                if (is_letter(b) || is_decimal(b))
                    add_token(1'b1, b, 1'b0, CL_IDENT);
                else
                begin
                    add_token(1'b0, 8'd0, 1'b1, CL_IDENT);
                    lx_state = ST_START;
                    again    = 1'b1;
                end
            end
            ST_NUM:
            begin
                if (is_decimal(b) || b == CH_PLUS || b == CH_MINUS)
                    add_token(1'b1, b, 1'b0, CL_NUM);
                else
                begin
                    add_token(1'b0, 8'd0, 1'b1, CL_NUM);
                    lx_state = ST_START;
                    again    = 1'b1;
                end
            end
            ST_STR1, ST_STR2:
            begin
                if (lx_esc)
                begin
                    lx_esc = 1'b0;
                    add_token(1'b1, b, 1'b0, CL_STR);
                end
                else if (b == quote)
                begin
                    add_token(1'b0, 8'd0, 1'b1, CL_STR);
                    lx_state = ST_START;
                end
                else if (b == CH_BSLASH)
                    lx_esc = 1'b1;
                else
                    add_token(1'b1, b, 1'b0, CL_STR);
            end
            default:
            begin
                lx_state = ST_START;
                if (b == CH_SPACE || b == CH_CR || b == CH_TAB)
                    lx_state = ST_START;
                else if (b == CH_LF)
                    bump_line();
                else if (is_single_punct(b))
                    add_token(1'b1, b, 1'b1, CL_PUNCT);
                else if (b == CH_SLASH)
                    lx_state = ST_SLASH;
                else if (is_letter(b))
                begin
                    lx_state = ST_IDENT;
                    add_token(1'b1, b, 1'b0, CL_IDENT);
                end
                else if (b == CH_PLUS || b == CH_MINUS || is_decimal(b))
                begin
                    lx_state = ST_NUM;
                    add_token(1'b1, b, 1'b0, CL_NUM);
                end
                else if (b == CH_SQUOTE)
                begin
                    lx_state = ST_STR1;
                    lx_esc   = 1'b0;
                end
                else if (b == CH_DQUOTE)
                begin
                    lx_state = ST_STR2;
                    lx_esc   = 1'b0;
                end
                else
                    add_token(1'b1, b, 1'b1, CL_UNK);
            end
        endcase
    endtask

    // tokens caused by one accepted request
    task automatic tokenize_request(input logic [7:0] b, input logic eoi);
        bit again;
        step_n = 0;
        if (eoi)
        begin
            lx_state = ST_START;
            lx_esc   = 1'b0;
            add_token(1'b0, 8'd0, 1'b1, CL_EOF);
        end
        else
        begin
            lex_pass(b, again);
            if (again)
                lex_pass(b, again);
        end
        if (step_n > 0)
            step_res[step_n - 1].last_result = 1'b1;
        for (int i = 0; i < step_n; i++)
            pending_tokens.push_back(step_res[i]);
    endtask

    task automatic add_byte(input logic [7:0] b);
        source_bytes.push_back('{code: b, eoi: 1'b0, drain: 1'b0, burst: 1'b0});
        queued++;
    endtask

    task automatic add_eoi(input logic drain);
        source_bytes.push_back('{code: 8'($urandom_range(0, 255)), eoi: 1'b1,
                                 drain: drain, burst: 1'b0});
        queued++;
    endtask

    function automatic logic [7:0] word_char(input bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26)
            return 8'("A" + r);
        else if (r < 52)
            return 8'("a" + r - 26);
        else if (r == 52)
            return CH_UNDER;
        return 8'("0" + r - 53);
    endfunction

    function automatic logic [7:0] num_char();
        int r;
        r = $urandom_range(0, 11);
        if (r == 10)
            return CH_PLUS;
        else if (r == 11)
            return CH_MINUS;
        return 8'("0" + r);
    endfunction

    // one token-shaped fragment of source text, now and then noise or a broken one
    task automatic add_fragment();
        int         pick;
        int         len;
        logic [7:0] quote;
        logic [7:0] c;
        string      punct_set;
        string      blank_set;
        punct_set = "{}&|*;=(),[]";
        blank_set = " \t\r\n";
        pick = $urandom_range(0, 99);
        len  = $urandom_range(0, 5);
        if (pick < 18)
        begin
            add_byte(word_char(1'b1));
            repeat (len) add_byte(word_char(1'b0));
        end
        else if (pick < 32)
        begin
            add_byte(num_char());
            repeat (len) add_byte(num_char());
        end
        else if (pick < 50)
        begin
            quote = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            add_byte(quote);
            repeat (len)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    add_byte(CH_BSLASH);
                    add_byte(8'($urandom_range(0, 255)));
                end
                else
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == quote || c == CH_BSLASH);
                    add_byte(c);
                end
            end
            // an unterminated string now and then
            if ($urandom_range(0, 19) != 0)
                add_byte(quote);
        end
        else if (pick < 62)
            add_byte(punct_set[$urandom_range(0, punct_set.len() - 1)]);
        else if (pick < 74)
            add_byte(blank_set[$urandom_range(0, blank_set.len() - 1)]);
        else if (pick < 80)
        begin
            add_byte(CH_SLASH);
            add_byte(CH_STAR);
            repeat (len)
            begin
                case ($urandom_range(0, 4))
                    0: add_byte(CH_STAR);
                    1: add_byte(CH_LF);
                    default: add_byte(8'($urandom_range(0, 255)));
                endcase
            end
            add_byte(CH_STAR);
            add_byte(CH_SLASH);
        end
        else if (pick < 85)
        begin
            add_byte(CH_SLASH);
            add_byte(CH_SLASH);
            repeat (len)
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_LF);
                add_byte(c);
            end
            add_byte(CH_LF);
        end
        else if (pick < 89)
            add_byte(CH_SLASH);
        else if (pick < 97)
            add_byte(8'($urandom_range(0, 255)));
        else
            add_eoi(1'b0);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            if (errors < REPORT_MAX)
                $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'd0;
            in_eoi   <= 1'b0;
        end
        else
        begin
            if (in_valid && byte_if.ready)
            begin
                tokenize_request(in_byte, in_eoi);
                sent_cnt++;
                tx_gap = (cur_burst || tx_calm) ? 0 : pick_gap();
                if ($urandom_range(0, 47) == 0)
                    tx_calm = !tx_calm;
            end
            if (in_valid && !byte_if.ready)
                in_valid <= 1'b1;
            else if (tx_gap != 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (source_bytes.size() != 0 &&
                     (!source_bytes[0].drain || pending_tokens.size() == 0))
            begin
                nxt = source_bytes.pop_front();
                in_valid  <= 1'b1;
                in_byte   <= nxt.code;
                in_eoi    <= nxt.eoi;
                cur_burst = nxt.burst;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // long receiver hold-off, once, while requests keep coming
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (!hold_used && sent_cnt >= HOLD_AT)
        begin
            hold_used = 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // token monitor and ready pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_ready && token_if.valid)
            begin
                if (pending_tokens.size() == 0)
                begin
                    if (errors < REPORT_MAX)
                        $error("token result with none expected");
                    errors++;
                end
                else
                begin
                    tok_want = pending_tokens.pop_front();
                    check_field("has_char", tok_want.has_char, token_if.has_char);
                    check_field("token_char", tok_want.token_char, token_if.token_char);
                    check_field("token_done", tok_want.token_done, token_if.token_done);
                    check_field("token_class", tok_want.token_class, token_if.token_class);
                    check_field("line_number", tok_want.line_number, token_if.line_number);
                    check_field("last_result", tok_want.last_result, token_if.last_result);
                end
            end
            if (rx_stall != 0)
                rx_stall--;
            else if (!rx_calm && $urandom_range(0, 3) == 0)
                rx_stall = pick_gap();
            if ($urandom_range(0, 127) == 0)
                rx_calm = !rx_calm;
            out_ready <= (rx_stall == 0) && (hold_left == 0);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        string dir_txt;
        // identifier ended by punctuation, signed run, lone slash before a letter,
        // escaped quote and newline in a string, empty string, block comment
        // with a newline and doubled star, high unknown byte, end inside a string
        dir_txt = "a9(-+ /q\"\\\"\\\n\"''/*\n**/";
        for (int i = 0; i < dir_txt.len(); i++)
            add_byte(dir_txt[i]);
        add_byte(8'hFF);
        add_byte(CH_SQUOTE);
        add_byte("x");
        add_eoi(1'b0);

        // random source text, first half
        queued = 0;
        while (queued < PHASE_ITEMS)
            add_fragment();

        // pause until every token is out
        add_eoi(1'b1);

        // random source text, second half
        queued = 0;
        while (queued < PHASE_ITEMS)
            add_fragment();
        add_eoi(1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (source_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
